// ----- hw/rtl/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP session engine package
// Shared types, codes and constants for the reassembly/retransmit unit.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int unsigned ReorderDepthDef = 8;
  localparam int unsigned UnackedDepthDef = 8;
  localparam int unsigned MaxResults      = 10;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [1:0] OP_RECV   = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [2:0] KIND_DELIVER = 3'd0;
  localparam logic [2:0] KIND_ACK     = 3'd1;
  localparam logic [2:0] KIND_XMIT    = 3'd2;
  localparam logic [2:0] KIND_REXMIT  = 3'd3;
  localparam logic [2:0] KIND_FIN     = 3'd4;

  localparam logic [1:0] REG_TIMEOUT    = 2'd0;
  localparam logic [1:0] REG_SEND_SEQ   = 2'd1;
  localparam logic [1:0] REG_EXPECT_SEQ = 2'd2;

  localparam logic [31:0] TimeoutReset = 32'd1000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] seg_seq;
    logic [15:0] seg_len;
    logic        ack_flag;
    logic [31:0] ack_value;
    logic [7:0]  payload_handle;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_seq;
    logic [15:0] out_len;
    logic [7:0]  out_handle;
    logic [31:0] out_ack;
    logic        table_full;
    logic        last;
  } result_t;

  function automatic logic seq_below(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ----- hw/rtl/tsr_front.sv -----
// ----------------------------------------------------------------------------
// TCP session front end
// Accepts items and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module tsr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  tsr_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output tsr_pkg::item_t item_o
);
  import tsr_pkg::*;

  item_t       mem_q [QueueDepth];
  logic        wp_q, rp_q, wp_d, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        wr, rd;

  assign full_o  = (cnt_q == 2'(QueueDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = take_i && valid_o;
  assign item_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wr ? ~wp_q : wp_q;
    rp_d  = rd ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue count overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !rd |=> cnt_q == 2'(QueueDepth)) else $error("write while full");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> wp_q == rp_q) else $error("pointer mismatch when empty");

endmodule

// ----- hw/rtl/tsr_engine.sv -----
// ----------------------------------------------------------------------------
// TCP session engine back end
// Scans the tables one slot per cycle unless output-stalled; emits results.
// ----------------------------------------------------------------------------
module tsr_engine #(
  parameter int unsigned REORDER_DEPTH = tsr_pkg::ReorderDepthDef,
  parameter int unsigned UNACKED_DEPTH = tsr_pkg::UnackedDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_take_o,
  input  tsr_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  output logic             res_empty_o,
  input  logic             res_pop_i,
  output tsr_pkg::result_t res_o
);
  import tsr_pkg::*;

  localparam int unsigned RW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
  localparam int unsigned UW = (UNACKED_DEPTH > 1) ? $clog2(UNACKED_DEPTH) : 1;
  localparam int unsigned RC = $clog2(REORDER_DEPTH + 1);
  localparam int unsigned UC = $clog2(UNACKED_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RSCAN = 3'd1;
  localparam logic [2:0] S_USCAN = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_ACKS  = 3'd5;

  logic [31:0] timeout_q, expect_q, send_q, tick_q;
  logic [REORDER_DEPTH-1:0] rv_q;
  logic [31:0] ro_seq_q [REORDER_DEPTH];
  logic [15:0] ro_len_q [REORDER_DEPTH];
  logic [7:0]  ro_hnd_q [REORDER_DEPTH];
  logic [UNACKED_DEPTH-1:0] uv_q;
  logic [31:0] ua_seq_q [UNACKED_DEPTH];
  logic [15:0] ua_len_q [UNACKED_DEPTH];
  logic [7:0]  ua_hnd_q [UNACKED_DEPTH];
  logic [31:0] ua_stp_q [UNACKED_DEPTH];

  logic [2:0]  st_q;
  item_t       it_q;
  logic [RC-1:0] ri_q;
  logic [UC-1:0] ui_q;
  logic        hit_q, fre_q;
  logic [RW-1:0] hs_q, fs_q;
  logic [UW-1:0] uh_q, uf_q;
  logic [3:0]  drn_q, nres_q;
  logic        fin_ack_q;

  // retransmit held back one step so the final one can carry last
  logic        pend_q;
  result_t     pres_q;

  logic        oput_q, oget_q, ovalid;
  result_t     ores_q;
  logic        oslot;

  assign ovalid      = oput_q ^ oget_q;
  assign oslot       = !ovalid || res_pop_i;
  assign res_empty_o = !ovalid;
  assign res_o       = ores_q;
  assign in_take_o   = (st_q == S_IDLE) && in_valid_i;

  logic [RW-1:0] rs;
  logic [UW-1:0] us;
  logic [31:0]   age;
  assign rs  = ri_q[RW-1:0];
  assign us  = ui_q[UW-1:0];
  assign age = tick_q - ua_stp_q[us];

  function automatic result_t mk(logic [2:0] k, logic [31:0] s, logic [15:0] l,
                                 logic [7:0] h, logic [31:0] a, logic f, logic z);
    result_t r;
    r.kind = k; r.out_seq = s; r.out_len = l; r.out_handle = h;
    r.out_ack = a; r.table_full = f; r.last = z;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oget_q <= 1'b0;
    end else if (ovalid && res_pop_i) begin
      oget_q <= ~oget_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      expect_q  <= 32'd0;
      send_q    <= 32'd0;
      tick_q    <= 32'd0;
      rv_q      <= '0;
      uv_q      <= '0;
      st_q      <= S_IDLE;
      oput_q    <= 1'b0;
      pend_q    <= 1'b0;
      ri_q <= '0; ui_q <= '0; hit_q <= 1'b0; fre_q <= 1'b0;
      hs_q <= '0; fs_q <= '0; uh_q <= '0; uf_q <= '0;
      drn_q <= '0; nres_q <= '0; fin_ack_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT:    timeout_q <= cfg_data_i;
          REG_SEND_SEQ:   send_q    <= cfg_data_i;
          REG_EXPECT_SEQ: expect_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            it_q <= item_i;
            ri_q <= '0; ui_q <= '0; hit_q <= 1'b0; fre_q <= 1'b0;
            drn_q <= '0; nres_q <= '0;
            case (item_i.operation)
              OP_RECV: begin
                if (item_i.ack_flag) st_q <= S_ACKS;
                else if (item_i.seg_seq == expect_q) begin
                  st_q <= S_EMIT; fin_ack_q <= 1'b0;
                end else if (!seq_below(item_i.seg_seq, expect_q)) st_q <= S_RSCAN;
                else begin st_q <= S_EMIT; fin_ack_q <= 1'b1; end
              end
              OP_SEND: st_q <= S_USCAN;
              OP_TICK: begin tick_q <= tick_q + 32'd1; st_q <= S_TICK; end
              default: st_q <= S_EMIT;
            endcase
          end
        end
        S_ACKS: begin
          if (ui_q == UC'(UNACKED_DEPTH)) st_q <= S_IDLE;
          else begin
            if (uv_q[us] && seq_below(ua_seq_q[us], it_q.ack_value)) uv_q[us] <= 1'b0;
            ui_q <= ui_q + 1'b1;
          end
        end
        S_RSCAN: begin
          if (ri_q == RC'(REORDER_DEPTH)) begin
            if (oslot) begin
              if (hit_q || fre_q) begin
                rv_q[hit_q ? hs_q : fs_q] <= 1'b1;
                ro_seq_q[hit_q ? hs_q : fs_q] <= it_q.seg_seq;
                ro_len_q[hit_q ? hs_q : fs_q] <= it_q.seg_len;
                ro_hnd_q[hit_q ? hs_q : fs_q] <= it_q.payload_handle;
              end
              ores_q <= mk(KIND_ACK, '0, '0, '0, expect_q, !(hit_q || fre_q), 1'b1);
              oput_q <= ~oput_q; st_q <= S_IDLE;
            end
          end else begin
            if (rv_q[rs] && ro_seq_q[rs] == it_q.seg_seq && !hit_q) begin
              hit_q <= 1'b1; hs_q <= rs;
            end
            if (!rv_q[rs] && !fre_q) begin fre_q <= 1'b1; fs_q <= rs; end
            ri_q <= ri_q + 1'b1;
          end
        end
        S_USCAN: begin
          if (ui_q == UC'(UNACKED_DEPTH)) begin
            if (oslot) begin
              if (hit_q || fre_q) begin
                uv_q[hit_q ? uh_q : uf_q] <= 1'b1;
                ua_seq_q[hit_q ? uh_q : uf_q] <= send_q;
                ua_len_q[hit_q ? uh_q : uf_q] <= it_q.seg_len;
                ua_hnd_q[hit_q ? uh_q : uf_q] <= it_q.payload_handle;
                ua_stp_q[hit_q ? uh_q : uf_q] <= tick_q;
              end
              ores_q <= mk(KIND_XMIT, send_q, it_q.seg_len, it_q.payload_handle,
                           '0, !(hit_q || fre_q), 1'b1);
              oput_q <= ~oput_q;
              send_q <= send_q + {16'd0, it_q.seg_len};
              st_q <= S_IDLE;
            end
          end else begin
            if (uv_q[us] && ua_seq_q[us] == send_q && !hit_q) begin
              hit_q <= 1'b1; uh_q <= us;
            end
            if (!uv_q[us] && !fre_q) begin fre_q <= 1'b1; uf_q <= us; end
            ui_q <= ui_q + 1'b1;
          end
        end
        S_TICK: begin
          if (ui_q == UC'(UNACKED_DEPTH) || nres_q == 4'(MaxResults)) begin
            if (!pend_q) st_q <= S_IDLE;
            else if (oslot) begin
              ores_q <= mk(KIND_REXMIT, pres_q.out_seq, pres_q.out_len,
                           pres_q.out_handle, '0, 1'b0, 1'b1);
              oput_q <= ~oput_q;
              pend_q <= 1'b0;
              st_q <= S_IDLE;
            end
          end else if (uv_q[us] && age > timeout_q) begin
            if (!pend_q || oslot) begin
              if (pend_q) begin
                ores_q <= mk(KIND_REXMIT, pres_q.out_seq, pres_q.out_len,
                             pres_q.out_handle, '0, 1'b0, 1'b0);
                oput_q <= ~oput_q;
              end
              pres_q <= mk(KIND_REXMIT, ua_seq_q[us], ua_len_q[us], ua_hnd_q[us],
                           '0, 1'b0, 1'b0);
              pend_q <= 1'b1;
              ua_stp_q[us] <= tick_q;
              nres_q <= nres_q + 4'd1;
              ui_q <= ui_q + 1'b1;
            end
          end else ui_q <= ui_q + 1'b1;
        end
        default: begin
          // S_EMIT: deliver/drain/ack or FIN
          if (it_q.operation == OP_FINISH) begin
            if (oslot) begin
              ores_q <= mk(KIND_FIN, send_q, '0, '0, '0, 1'b0, 1'b1);
              oput_q <= ~oput_q; st_q <= S_IDLE;
            end
          end else if (fin_ack_q) begin
            if (oslot) begin
              ores_q <= mk(KIND_ACK, '0, '0, '0, expect_q, 1'b0, 1'b1);
              oput_q <= ~oput_q; st_q <= S_IDLE;
            end
          end else if (drn_q == 4'd0) begin
            if (oslot) begin
              ores_q <= mk(KIND_DELIVER, it_q.seg_seq, it_q.seg_len,
                           it_q.payload_handle, '0, 1'b0, 1'b0);
              oput_q <= ~oput_q;
              expect_q <= expect_q + {16'd0, it_q.seg_len};
              drn_q <= 4'd1; ri_q <= '0;
            end
          end else if (ri_q == RC'(REORDER_DEPTH) || drn_q == 4'(MaxResults - 1)) begin
            fin_ack_q <= 1'b1;
          end else if (rv_q[rs] && ro_seq_q[rs] == expect_q) begin
            if (oslot) begin
              ores_q <= mk(KIND_DELIVER, ro_seq_q[rs], ro_len_q[rs], ro_hnd_q[rs],
                           '0, 1'b0, 1'b0);
              oput_q <= ~oput_q;
              rv_q[rs] <= 1'b0;
              expect_q <= expect_q + {16'd0, ro_len_q[rs]};
              drn_q <= drn_q + 4'd1; ri_q <= '0;
            end
          end else ri_q <= ri_q + 1'b1;
        end
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take_o |-> st_q == S_IDLE) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid && !res_pop_i |=> ovalid && $stable(ores_q))
    else $error("result overwritten");
  a_drain_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drn_q <= 4'(MaxResults - 1)) else $error("drain beyond limit");

endmodule

// ----- hw/rtl/tcp_segment_reassembly_retransmit_unit.sv -----
// ----------------------------------------------------------------------------
// TCP segment reassembly and retransmit unit
// Table scans take one slot per cycle, pausing only while a result waits for
// room in the full output register; sends, out-of-order and ACK segments and
// ticks scan a whole table, and an in-order drain rescans the reorder table
// for each drained segment. No new item is taken before the last one is done.
// Reset clears all valid bits at once; no clearing pass.
module tcp_segment_reassembly_retransmit_unit #(
  parameter int unsigned REORDER_DEPTH = tsr_pkg::ReorderDepthDef,
  parameter int unsigned UNACKED_DEPTH = tsr_pkg::UnackedDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seg_seq_i,
  input  logic [15:0] seg_len_i,
  input  logic        ack_flag_i,
  input  logic [31:0] ack_value_i,
  input  logic [7:0]  payload_handle_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] out_seq_o,
  output logic [15:0] out_len_o,
  output logic [7:0]  out_handle_o,
  output logic [31:0] out_ack_o,
  output logic        table_full_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tsr_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_take;

  assign in_item.operation      = operation_i;
  assign in_item.seg_seq        = seg_seq_i;
  assign in_item.seg_len        = seg_len_i;
  assign in_item.ack_flag       = ack_flag_i;
  assign in_item.ack_value      = ack_value_i;
  assign in_item.payload_handle = payload_handle_i;
  assign cfg_ready_o = 1'b1;

  tsr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  tsr_engine #(.REORDER_DEPTH(REORDER_DEPTH), .UNACKED_DEPTH(UNACKED_DEPTH)) u_eng (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_take_o(q_take), .item_i(q_item),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .res_empty_o(empty), .res_pop_i(pop), .res_o(res)
  );

  assign kind_o       = res.kind;
  assign out_seq_o    = res.out_seq;
  assign out_len_o    = res.out_len;
  assign out_handle_o = res.out_handle;
  assign out_ack_o    = res.out_ack;
  assign table_full_o = res.table_full;
  assign last_o       = res.last;

endmodule

// ----- tb/tcp_segment_reassembly_retransmit_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP session engine checker
// Watches the item, result and register channels, keeps a shadow of the
// session state, works out the expected results of every accepted item and
// compares them in order with the results the unit emits.
// ----------------------------------------------------------------------------
module tcp_segment_reassembly_retransmit_unit_checker
  import tsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seg_seq_i,
  input  logic [15:0] seg_len_i,
  input  logic        ack_flag_i,
  input  logic [31:0] ack_value_i,
  input  logic [7:0]  payload_handle_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  kind_o,
  input  logic [31:0] out_seq_o,
  input  logic [15:0] out_len_o,
  input  logic [7:0]  out_handle_o,
  input  logic [31:0] out_ack_o,
  input  logic        table_full_o,
  input  logic        last_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count,
  output int          pending_count
);

  localparam int Depth = 8;

  typedef struct {
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  hnd;
    logic [31:0] stamp;
  } slot_t;

  logic [31:0] timeout_r, expect_r, send_seq_r, ticks_r;
  logic        ro_vld[Depth];
  slot_t       ro_tab[Depth];
  logic        ua_vld[Depth];
  slot_t       ua_tab[Depth];
  result_t     expected_q[$];
  result_t     batch_q[$];

  assign pending_count = expected_q.size();

  function automatic logic is_below(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic result_t mk(logic [2:0] k, logic [31:0] s, logic [15:0] l,
                                 logic [7:0] h, logic [31:0] a, logic f);
    result_t r;
    r.kind = k; r.out_seq = s; r.out_len = l; r.out_handle = h;
    r.out_ack = a; r.table_full = f; r.last = 1'b0;
    return r;
  endfunction

  function automatic int ro_find(logic [31:0] s);
    for (int i = 0; i < Depth; i++) if (ro_vld[i] && ro_tab[i].seq == s) return i;
    return -1;
  endfunction

  task automatic predict_session(item_t it);
    int k, drained;
    logic fl;
    batch_q.delete();
    case (it.operation)
      OP_RECV: begin
        if (it.ack_flag) begin
          for (int i = 0; i < Depth; i++)
            if (ua_vld[i] && is_below(ua_tab[i].seq, it.ack_value)) ua_vld[i] = 1'b0;
        end else if (it.seg_seq == expect_r) begin
          batch_q.push_back(mk(KIND_DELIVER, it.seg_seq, it.seg_len,
                               it.payload_handle, '0, 1'b0));
          expect_r += 32'(it.seg_len);
          drained = 0;
          while (drained < MaxResults - 2) begin
            k = ro_find(expect_r);
            if (k < 0) break;
            batch_q.push_back(mk(KIND_DELIVER, ro_tab[k].seq, ro_tab[k].len,
                                 ro_tab[k].hnd, '0, 1'b0));
            ro_vld[k] = 1'b0;
            expect_r += 32'(ro_tab[k].len);
            drained++;
          end
          batch_q.push_back(mk(KIND_ACK, '0, '0, '0, expect_r, 1'b0));
        end else if (!is_below(it.seg_seq, expect_r)) begin
          fl = 1'b0;
          k = ro_find(it.seg_seq);
          if (k < 0)
            for (int i = 0; i < Depth; i++) if (!ro_vld[i]) begin k = i; break; end
          if (k < 0) fl = 1'b1;
          else begin
            ro_vld[k] = 1'b1;
            ro_tab[k].seq = it.seg_seq; ro_tab[k].len = it.seg_len;
            ro_tab[k].hnd = it.payload_handle;
          end
          batch_q.push_back(mk(KIND_ACK, '0, '0, '0, expect_r, fl));
        end else begin
          batch_q.push_back(mk(KIND_ACK, '0, '0, '0, expect_r, 1'b0));
        end
      end
      OP_SEND: begin
        fl = 1'b0;
        k = -1;
        for (int i = 0; i < Depth; i++)
          if (ua_vld[i] && ua_tab[i].seq == send_seq_r) begin k = i; break; end
        if (k < 0)
          for (int i = 0; i < Depth; i++) if (!ua_vld[i]) begin k = i; break; end
        if (k < 0) fl = 1'b1;
        else begin
          ua_vld[k] = 1'b1;
          ua_tab[k].seq = send_seq_r; ua_tab[k].len = it.seg_len;
          ua_tab[k].hnd = it.payload_handle; ua_tab[k].stamp = ticks_r;
        end
        batch_q.push_back(mk(KIND_XMIT, send_seq_r, it.seg_len, it.payload_handle,
                             '0, fl));
        send_seq_r += 32'(it.seg_len);
      end
      OP_TICK: begin
        ticks_r += 32'd1;
        for (int i = 0; i < Depth && batch_q.size() < MaxResults; i++)
          if (ua_vld[i] && (ticks_r - ua_tab[i].stamp) > timeout_r) begin
            batch_q.push_back(mk(KIND_REXMIT, ua_tab[i].seq, ua_tab[i].len,
                                 ua_tab[i].hnd, '0, 1'b0));
            ua_tab[i].stamp = ticks_r;
          end
      end
      default: batch_q.push_back(mk(KIND_FIN, send_seq_r, '0, '0, '0, 1'b0));
    endcase
    if (batch_q.size() > 0) batch_q[batch_q.size()-1].last = 1'b1;
    foreach (batch_q[i]) expected_q.push_back(batch_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    result_t got, exp_r;
    if (!rst_ni) begin
      timeout_r = TimeoutReset; expect_r = '0; send_seq_r = '0; ticks_r = '0;
      for (int i = 0; i < Depth; i++) begin ro_vld[i] = 1'b0; ua_vld[i] = 1'b0; end
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        got = '{kind_o, out_seq_o, out_len_o, out_handle_o, out_ack_o,
                table_full_o, last_o};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch exp %p got %p", exp_r, got);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TIMEOUT:    timeout_r = cfg_data_i;
          REG_SEND_SEQ:   send_seq_r = cfg_data_i;
          REG_EXPECT_SEQ: expect_r = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        it = '{operation_i, seg_seq_i, seg_len_i, ack_flag_i, ack_value_i,
               payload_handle_i};
        predict_session(it);
      end
    end
  end

endmodule

// ----- tb/tcp_segment_reassembly_retransmit_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP session engine testbench
// Drives directed and random session traffic (in-order, reordered, stale and
// ACK segments, sends, ticks, finishes) through several register settings
// with random idling on both sides; the checker compares every result.
// ----------------------------------------------------------------------------
module tcp_segment_reassembly_retransmit_unit_tb;
  import tsr_pkg::*;

  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = OP_FINISH;
  logic [31:0] seg_seq_i = '0;
  logic [15:0] seg_len_i = '0;
  logic        ack_flag_i = 1'b0;
  logic [31:0] ack_value_i = '0;
  logic [7:0]  payload_handle_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] out_seq_o, out_ack_o;
  logic [15:0] out_len_o;
  logic [7:0]  out_handle_o;
  logic        table_full_o, last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_TIMEOUT;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending_count;
  int          idle_cycles = 0;
  logic [31:0] peer_seq, my_seq;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tcp_segment_reassembly_retransmit_unit i_dut (.*);
  tcp_segment_reassembly_retransmit_unit_checker i_chk (.*);

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls per item, with a stall-free stretch
  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk_i);
      if (!pop) begin
        repeat ((n % 200 < 40) ? 0 : $urandom_range(0, 9)) @(posedge clk_i);
        pop <= 1'b1;
      end else if (!empty) begin
        n++;
        pop <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] s, logic [15:0] l,
                           logic af, logic [31:0] av, logic [7:0] h, bit gap);
    if (gap) repeat ($urandom_range(0, 9)) @(posedge clk_i);
    push <= 1'b1; operation_i <= op; seg_seq_i <= s; seg_len_i <= l;
    ack_flag_i <= af; ack_value_i <= av; payload_handle_i <= h;
    do @(posedge clk_i); while (full);
    push <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item(bit gap);
    int r;
    logic [15:0] l;
    r = $urandom_range(0, 99);
    l = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    if (r < 35) begin
      if ($urandom_range(0, 2) == 0) begin
        send_item(OP_RECV, peer_seq, l, 1'b0, 32'($urandom), 8'($urandom), gap);
        peer_seq += 32'(l);
      end else
        send_item(OP_RECV, peer_seq + 32'($urandom_range(1, 300)), l, 1'b0,
                  32'($urandom), 8'($urandom), gap);
    end else if (r < 45)
      send_item(OP_RECV, ($urandom_range(0, 3) == 0) ? 32'($urandom)
                : peer_seq - 32'($urandom_range(1, 100)), l, 1'b0, 32'($urandom),
                8'($urandom), gap);
    else if (r < 57)
      send_item(OP_RECV, 32'($urandom), l, 1'b1,
                ($urandom_range(0, 3) == 0) ? 32'($urandom)
                : my_seq - 32'($urandom_range(0, 200)), 8'($urandom), gap);
    else if (r < 75) begin
      send_item(OP_SEND, 32'($urandom), l, 1'($urandom), 32'($urandom),
                8'($urandom), gap);
      my_seq += 32'(l);
    end else if (r < 95)
      send_item(OP_TICK, 32'($urandom), 16'($urandom), 1'($urandom), 32'($urandom),
                8'($urandom), gap);
    else
      send_item(OP_FINISH, 32'($urandom), 16'($urandom), 1'($urandom),
                32'($urandom), 8'($urandom), gap);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, wrap, reorder/drain, stale, full tables, finish
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_SEND_SEQ, 32'hFFFF_FFF0);
    write_reg(REG_EXPECT_SEQ, 32'hFFFF_FFF0);
    for (int i = 1; i <= 9; i++)
      send_item(OP_RECV, 32'hFFFF_FFF0 + 32'(i * 16), 16'd16, 1'b0, '0, 8'(i), 1);
    send_item(OP_RECV, 32'hFFFF_FFF0, 16'd16, 1'b0, '0, 8'hFF, 1);
    send_item(OP_RECV, 32'h0000_0000, 16'hFFFF, 1'b0, '1, 8'h00, 1);
    for (int i = 0; i < 9; i++)
      send_item(OP_SEND, '1, (i == 0) ? 16'hFFFF : 16'd8, 1'b1, '1, 8'(i), 1);
    send_item(OP_TICK, '0, '0, 1'b0, '0, '0, 1);
    send_item(OP_FINISH, '1, '1, 1'b1, '1, '1, 1);
    send_item(OP_RECV, '0, 16'd4, 1'b1, 32'h8000_0000, 8'h55, 1);
    send_item(OP_RECV, '1, 16'd4, 1'b1, '0, 8'hAA, 1);

    peer_seq = 32'd500; my_seq = 32'd0;
    write_reg(REG_EXPECT_SEQ, peer_seq);
    write_reg(REG_SEND_SEQ, my_seq);
    write_reg(REG_TIMEOUT, 32'd3);
    for (int i = 0; i < 90; i++) random_item(i > 20);

    // pause until the engine has drained everything
    while (pending_count != 0) @(posedge clk_i);
    for (int i = 0; i < 40; i++) random_item(1);

    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    peer_seq = 32'h7FFF_FF00; my_seq = 32'h8000_0000;
    write_reg(REG_EXPECT_SEQ, peer_seq);
    write_reg(REG_SEND_SEQ, my_seq);
    for (int i = 0; i < 60; i++) random_item(1);

    write_reg(REG_TIMEOUT, 32'd1);
    for (int i = 0; i < 70; i++) random_item(i % 30 > 8);

    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_front.sv
hw/rtl/tsr_engine.sv
hw/rtl/tcp_segment_reassembly_retransmit_unit.sv
tb/tcp_segment_reassembly_retransmit_unit_checker.sv
tb/tcp_segment_reassembly_retransmit_unit_tb.sv
